// ===== rtl/hte_pkg.sv =====
// ----------------------------------------------------------------------------
// hte_pkg: shared types and constants for the Huffman table encoder
// Command codes, table entry layout and the byte queue request format.
// ----------------------------------------------------------------------------
package hte_pkg;

  localparam int unsigned MAX_CODE_LEN = 32;

  localparam int unsigned SYM_W       = 8;
  localparam int unsigned CODE_W      = 32;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PEND_W      = BYTE_W - 1;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned WORD_W      = BYTE_W + CODE_W;
  localparam int unsigned NB_W        = 3;
  localparam int unsigned BIDX_W      = 2;
  localparam int unsigned TABLE_DEPTH = 1 << SYM_W;
  localparam int unsigned Q_DEPTH     = 2;
  localparam int unsigned QPTR_W      = $clog2(Q_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(Q_DEPTH + 1);

  // stored length saturates to the smaller of the code field and the max length
  localparam logic [LEN_W-1:0] LEN_CAP =
    LEN_W'((MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } tbl_entry_t;

  // left-aligned bit word, number of complete bytes in it, final-byte flag
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [NB_W-1:0]   nbytes;
    logic              last;
  } pack_req_t;

endpackage

// ===== rtl/hte_byte_queue.sv =====
// ----------------------------------------------------------------------------
// hte_byte_queue: byte word queue and serializer
// Holds up to two packed words and hands out their bytes one per request.
// ----------------------------------------------------------------------------
module hte_byte_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  hte_pkg::pack_req_t             req_i,
  output logic                           full_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [hte_pkg::BYTE_W-1:0]     packed_byte_o,
  output logic                           last_of_run_o
);

  hte_pkg::pack_req_t                ent_q [hte_pkg::Q_DEPTH];
  logic [hte_pkg::QPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [hte_pkg::QCNT_W-1:0]        cnt_q, cnt_d;
  logic [hte_pkg::BIDX_W-1:0]        bi_q;
  hte_pkg::pack_req_t                head;
  logic [hte_pkg::WORD_W-1:0]        head_sh;
  logic                              out_acc, last_byte, pop;

  assign head      = ent_q[rd_ptr_q];
  assign head_sh   = head.word << {bi_q, 3'b000};
  assign last_byte = (hte_pkg::NB_W'(bi_q) + hte_pkg::NB_W'(1)) >= head.nbytes;

  assign out_valid_o   = (cnt_q != '0);
  assign full_o        = (cnt_q == hte_pkg::QCNT_W'(hte_pkg::Q_DEPTH));
  assign packed_byte_o = head_sh[hte_pkg::WORD_W-1 -: hte_pkg::BYTE_W];
  assign last_of_run_o = head.last;

  assign out_acc = out_valid_o && !out_stall_i;
  assign pop     = out_acc && last_byte;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + hte_pkg::QCNT_W'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - hte_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      bi_q     <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + hte_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + hte_pkg::QPTR_W'(1);
        bi_q     <= '0;
      end else if (out_acc) begin
        bi_q <= bi_q + hte_pkg::BIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= req_i;
    end
  end

endmodule

// ===== rtl/huffman_table_encoder_byte_packer_core.sv =====
// A request is registered in the table read stage, then pushed into the byte queue, which presents its first byte.
// Throughput: one request per cycle while bytes drain; an encode that completes
// n bytes holds the byte port until all n are taken, and a two-entry word queue absorbs
// the difference, so input stalls only when that queue is full.
// Reset clears the pipeline, the bit accumulator and the byte queue; the code
// table is not cleared and an entry is undefined until loaded.
// ----------------------------------------------------------------------------
// huffman_table_encoder_byte_packer_core: static-table Huffman encoder
// Code table in a synchronous RAM with a registered read, bit accumulator, byte packer.
// ----------------------------------------------------------------------------
module huffman_table_encoder_byte_packer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [hte_pkg::SYM_W-1:0]     symbol_i,
  input  logic [hte_pkg::CODE_W-1:0]    code_bits_i,
  input  logic [hte_pkg::LEN_W-1:0]     code_length_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hte_pkg::BYTE_W-1:0]    packed_byte_o,
  output logic                          last_of_run_o
);

  hte_pkg::tbl_entry_t               mem [hte_pkg::TABLE_DEPTH];
  hte_pkg::tbl_entry_t               wr_entry, rd_q;

  logic                              in_acc;
  logic                              s1_valid_q;
  logic [1:0]                        s1_cmd_q;
  logic [hte_pkg::PEND_W-1:0]        pend_q, pend_d;
  logic [hte_pkg::CNT_W-1:0]         pcnt_q, pcnt_d;

  logic [hte_pkg::LEN_W-1:0]         code_sh;
  logic [hte_pkg::CODE_W-1:0]        code_al;
  logic [hte_pkg::WORD_W-1:0]        pend_word, word_enc, word_sh;
  logic [hte_pkg::LEN_W:0]           total;
  logic [hte_pkg::NB_W-1:0]          nbytes;
  logic                              push_valid, q_full, s1_adv;
  hte_pkg::pack_req_t                req;

  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    wr_entry.code = code_bits_i;
    wr_entry.len  = (code_length_i > hte_pkg::LEN_CAP) ? hte_pkg::LEN_CAP : code_length_i;
  end

  // table: write on load, registered read on encode
  always_ff @(posedge clk_i) begin
    if (in_acc && command_i == hte_pkg::CMD_LOAD) begin
      mem[symbol_i] <= wr_entry;
    end
    if (in_acc && command_i == hte_pkg::CMD_ENCODE) begin
      rd_q <= mem[symbol_i];
    end
  end

  // left-align the code, then place it behind the pending bits
  always_comb begin
    code_sh   = hte_pkg::LEN_W'(hte_pkg::CODE_W) - rd_q.len;
    code_al   = rd_q.code << code_sh;
    pend_word = {pend_q, 1'b0, {hte_pkg::CODE_W{1'b0}}};
    word_enc  = pend_word | ({code_al, {hte_pkg::BYTE_W{1'b0}}} >> pcnt_q);
    total     = (hte_pkg::LEN_W+1)'(pcnt_q) + (hte_pkg::LEN_W+1)'(rd_q.len);
    nbytes    = hte_pkg::NB_W'(total >> 3);
    word_sh   = word_enc << {nbytes, 3'b000};
  end

  always_comb begin
    push_valid = 1'b0;
    req.word   = word_enc;
    req.nbytes = nbytes;
    req.last   = 1'b0;
    pend_d     = pend_q;
    pcnt_d     = pcnt_q;
    case (s1_cmd_q)
      hte_pkg::CMD_ENCODE: begin
        push_valid = s1_valid_q && (nbytes != '0);
        pend_d     = word_sh[hte_pkg::WORD_W-1 -: hte_pkg::PEND_W];
        pcnt_d     = total[hte_pkg::CNT_W-1:0];
      end
      hte_pkg::CMD_FLUSH: begin
        push_valid = s1_valid_q && (pcnt_q != '0);
        req.word   = pend_word;
        req.nbytes = hte_pkg::NB_W'(1);
        req.last   = 1'b1;
        pend_d     = '0;
        pcnt_d     = '0;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

  assign s1_adv     = !push_valid || !q_full;
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_cmd_q   <= hte_pkg::CMD_LOAD;
      pend_q     <= '0;
      pcnt_q     <= '0;
    end else begin
      s1_valid_q <= in_acc || (s1_valid_q && !s1_adv);
      if (in_acc) begin
        s1_cmd_q <= command_i;
      end
      if (s1_valid_q && s1_adv) begin
        pend_q <= pend_d;
        pcnt_q <= pcnt_d;
      end
    end
  end

  hte_byte_queue u_byte_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_valid && !q_full),
    .req_i         (req),
    .full_o        (q_full),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .packed_byte_o (packed_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== rtl/hte_checker.sv =====
// ----------------------------------------------------------------------------
// hte_checker: port-level checks for the Huffman encoder core
// Handshake stability, stall cause, byte timing and flush padding.
// ----------------------------------------------------------------------------
module hte_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [hte_pkg::BYTE_W-1:0] packed_byte_o,
  input logic                       last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("byte request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(packed_byte_o) && $stable(last_of_run_o))
    else $error("byte payload changed while stalled");

  // input only backs up behind a pending byte
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no byte pending");

  // a byte from an idle queue comes from a request that passed the table read stage and the queue push
  a_byte_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("byte appeared without a matching request");

  // flushed byte holds at most seven bits, so its lowest bit is padding
  a_flush_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_run_o |-> !packed_byte_o[0])
    else $error("flush byte not zero padded");

endmodule

bind huffman_table_encoder_byte_packer_core hte_checker u_hte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .packed_byte_o (packed_byte_o),
  .last_of_run_o (last_of_run_o)
);
